// ===== rtl/humidity_sensor_frame_check_convert_unit_defines.svh =====
// Assertion macros used by the frame check and convert unit RTL.
`ifndef HUMIDITY_SENSOR_FRAME_CHECK_CONVERT_UNIT_DEFINES_SVH
`define HUMIDITY_SENSOR_FRAME_CHECK_CONVERT_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HSFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("hsfc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define HSFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("hsfc: next-cycle check failed");

`endif

// ===== rtl/hsfc_pkg.sv =====
// Shared constants and the CRC-8 byte step for the frame check and convert block.
package hsfc_pkg;

	localparam logic [7:0]         CRC_POLY    = 8'h31;
	localparam logic [7:0]         CRC_INIT    = 8'hFF;
	localparam logic [14:0]        TEMP_SPAN   = 15'd17500;
	localparam logic [13:0]        HUM_SPAN    = 14'd10000;
	localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;

	// One byte through the CRC-8 register, MSB first, no reflection.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
		logic [7:0] crc;
		crc = crc_in ^ data;
		for (int b = 0; b < 8; b++) begin
			if (crc[7]) begin
				crc = {crc[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				crc = {crc[6:0], 1'b0};
			end
		end
		return crc;
	endfunction

endpackage

// ===== rtl/hsfc_if.sv =====
// Frame input and result output channel interfaces.
interface hsfc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] temperature_high;
	logic [7:0] temperature_low;
	logic [7:0] temperature_check;
	logic [7:0] humidity_high;
	logic [7:0] humidity_low;
	logic [7:0] humidity_check;

	modport source (
		output valid, temperature_high, temperature_low, temperature_check,
		       humidity_high, humidity_low, humidity_check,
		input  ready
	);
	modport sink (
		input  valid, temperature_high, temperature_low, temperature_check,
		       humidity_high, humidity_low, humidity_check,
		output ready
	);
endinterface

interface hsfc_out_if;
	logic               valid;
	logic               ready;
	logic               frame_valid;
	logic signed [14:0] temperature_centi;
	logic        [13:0] humidity_centi;

	modport source (
		output valid, frame_valid, temperature_centi, humidity_centi,
		input  ready
	);
	modport sink (
		input  valid, frame_valid, temperature_centi, humidity_centi,
		output ready
	);
endinterface

// ===== rtl/hsfc_crc_check.sv =====
// Two-stage CRC-8 check of both raw words of a frame.
module hsfc_crc_check
	import hsfc_pkg::*;
(
	input  logic       clk,
	input  logic       advance,
	input  logic [7:0] temperature_high,
	input  logic [7:0] temperature_low,
	input  logic [7:0] temperature_check,
	input  logic [7:0] humidity_high,
	input  logic [7:0] humidity_low,
	input  logic [7:0] humidity_check,
	output logic       crc_ok_s2
);

	logic [7:0] crc_t_s1, crc_h_s1;
	logic [7:0] lo_t_s1, lo_h_s1;
	logic [7:0] ck_t_s1, ck_h_s1;

	// Stage 1: high byte through the CRC register
	always_ff @(posedge clk) begin
		if (advance) begin
			crc_t_s1 <= crc8_byte(CRC_INIT, temperature_high);
			crc_h_s1 <= crc8_byte(CRC_INIT, humidity_high);
			lo_t_s1  <= temperature_low;
			lo_h_s1  <= humidity_low;
			ck_t_s1  <= temperature_check;
			ck_h_s1  <= humidity_check;
		end
	end

	// Stage 2: low byte, then compare against received check bytes
	always_ff @(posedge clk) begin
		if (advance) begin
			crc_ok_s2 <= (crc8_byte(crc_t_s1, lo_t_s1) == ck_t_s1) &&
				(crc8_byte(crc_h_s1, lo_h_s1) == ck_h_s1);
		end
	end

endmodule

// ===== rtl/hsfc_scale.sv =====
// Two-stage fixed-point scaling of raw words: multiply, then divide by 65535.
module hsfc_scale
	import hsfc_pkg::*;
(
	input  logic        clk,
	input  logic        advance,
	input  logic [15:0] raw_t,
	input  logic [15:0] raw_h,
	output logic [14:0] quot_t_s2,
	output logic [13:0] quot_h_s2
);

	logic [30:0] prod_t_s1;
	logic [29:0] prod_h_s1;
	logic [31:0] sum_t;
	logic [30:0] sum_h;

	// Stage 1: exact products
	always_ff @(posedge clk) begin
		if (advance) begin
			prod_t_s1 <= {15'd0, raw_t} * {16'd0, TEMP_SPAN};
			prod_h_s1 <= {14'd0, raw_h} * {16'd0, HUM_SPAN};
		end
	end

	// floor(x / 65535) = (x + (x >> 16) + 1) >> 16 while the quotient stays below 2^16
	assign sum_t = {1'b0, prod_t_s1} + {17'd0, prod_t_s1[30:16]} + 32'd1;
	assign sum_h = {1'b0, prod_h_s1} + {17'd0, prod_h_s1[29:16]} + 31'd1;

	// Stage 2: quotients
	always_ff @(posedge clk) begin
		if (advance) begin
			quot_t_s2 <= sum_t[30:16];
			quot_h_s2 <= sum_h[29:16];
		end
	end

endmodule

// ===== rtl/humidity_sensor_frame_check_convert_unit.sv =====
// An accepted frame beat passes stages 1 and 2 into the stage 3 output register.
// Throughput: one frame per cycle; three register stages advance together.
// A stall on the result side holds all stages; input ready drops only while
// the output register is full and not taken.
// Reset (arst_n low, asynchronous) clears the stage valid bits; data registers hold.
`include "humidity_sensor_frame_check_convert_unit_defines.svh"

module humidity_sensor_frame_check_convert_unit
	import hsfc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	hsfc_in_if.sink    frame,
	hsfc_out_if.source result
);

	logic               advance;
	logic               valid_s1, valid_s2, valid_s3;
	logic               crc_ok_s2;
	logic        [14:0] quot_t_s2;
	logic        [13:0] quot_h_s2;
	logic signed [15:0] temp_full;
	logic               frame_valid_s3;
	logic signed [14:0] temperature_s3;
	logic        [13:0] humidity_s3;

	// Whole pipeline moves when the output register is free or being taken
	assign advance     = !valid_s3 || result.ready;
	assign frame.ready = advance;

	hsfc_crc_check u_crc (
		.clk               (clk),
		.advance           (advance),
		.temperature_high  (frame.temperature_high),
		.temperature_low   (frame.temperature_low),
		.temperature_check (frame.temperature_check),
		.humidity_high     (frame.humidity_high),
		.humidity_low      (frame.humidity_low),
		.humidity_check    (frame.humidity_check),
		.crc_ok_s2         (crc_ok_s2)
	);

	hsfc_scale u_scale (
		.clk       (clk),
		.advance   (advance),
		.raw_t     ({frame.temperature_high, frame.temperature_low}),
		.raw_h     ({frame.humidity_high, frame.humidity_low}),
		.quot_t_s2 (quot_t_s2),
		.quot_h_s2 (quot_h_s2)
	);

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= frame.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Offset removal
	assign temp_full = $signed({1'b0, quot_t_s2}) - TEMP_OFFSET;

	// Stage 3: output register, results zeroed on CRC failure
	always_ff @(posedge clk) begin
		if (advance) begin
			frame_valid_s3 <= crc_ok_s2;
			temperature_s3 <= crc_ok_s2 ? temp_full[14:0] : 15'sd0;
			humidity_s3    <= crc_ok_s2 ? quot_h_s2 : 14'd0;
		end
	end

	assign result.valid             = valid_s3;
	assign result.frame_valid       = frame_valid_s3;
	assign result.temperature_centi = temperature_s3;
	assign result.humidity_centi    = humidity_s3;

	// Failed frames carry zero results
	`HSFC_ASSERT_NOW(a_fail_zero, clk, arst_n,
		result.valid && !result.frame_valid,
		result.temperature_centi == 15'sd0 && result.humidity_centi == 14'd0)
	// Converted values stay in range
	`HSFC_ASSERT_NOW(a_range, clk, arst_n,
		result.valid && result.frame_valid,
		result.humidity_centi <= 14'd10000 && result.temperature_centi >= -15'sd4500 &&
		result.temperature_centi <= 15'sd13000)
	// An accepted beat occupies stage 1 next cycle
	`HSFC_ASSERT_NEXT(a_enter, clk, arst_n, frame.valid && frame.ready, valid_s1)
	// A held result is never dropped by the stall logic
	`HSFC_ASSERT_NEXT(a_hold, clk, arst_n, result.valid && !result.ready,
		result.valid && valid_s2 == $past(valid_s2))

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the humidity sensor frame check and convert unit.
`timescale 1ns / 1ps

module tb_top;
	import hsfc_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 8;

	// Receiver stall patterns
	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_PATTERN,
		STALL_HEAVY
	} stall_mode_t;

	typedef struct packed {
		logic [7:0] t_hi, t_lo, t_ck, h_hi, h_lo, h_ck;
	} sensor_frame_t;

	typedef struct packed {
		logic               frame_ok;
		logic signed [14:0] temperature_centi;
		logic        [13:0] humidity_centi;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n;

	hsfc_in_if  frame();
	hsfc_out_if result();

	humidity_sensor_frame_check_convert_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame),
		.result (result)
	);

	always #1 clk = ~clk;

	reading_t    pending_readings[$];
	int          error_count = 0;
	int          idle_cycles = 0;
	stall_mode_t stall_mode  = STALL_NONE;
	logic [15:0] stall_pattern = 16'hFFFF;
	logic [3:0]  stall_phase   = '0;
	int          gap_pct   = 0;
	int          max_gap   = 1;
	int          burst_left = 0;

	// Bit-serial CRC-8 over one 16-bit word, MSB first
	function automatic logic [7:0] word_crc(input logic [15:0] word);
		logic [7:0] crc;
		logic       fb;
		crc = CRC_INIT;
		for (int i = 15; i >= 0; i--) begin
			fb  = crc[7] ^ word[i];
			crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return crc;
	endfunction

	// Frame with correct check bytes for both words
	function automatic sensor_frame_t with_crc(input logic [15:0] raw_t, input logic [15:0] raw_h);
		sensor_frame_t f;
		f.t_hi = raw_t[15:8];
		f.t_lo = raw_t[7:0];
		f.t_ck = word_crc(raw_t);
		f.h_hi = raw_h[15:8];
		f.h_lo = raw_h[7:0];
		f.h_ck = word_crc(raw_h);
		return f;
	endfunction

	// Expected reading for one frame
	function automatic reading_t convert_frame(input sensor_frame_t f);
		reading_t    r;
		logic [31:0] prod;
		int          temp;
		r = '0;
		if (word_crc({f.t_hi, f.t_lo}) == f.t_ck && word_crc({f.h_hi, f.h_lo}) == f.h_ck) begin
			r.frame_ok = 1'b1;
			prod = {16'd0, f.t_hi, f.t_lo} * 32'(TEMP_SPAN);
			temp = int'(prod / 32'd65535) - int'(TEMP_OFFSET);
			r.temperature_centi = temp[14:0];
			prod = {16'd0, f.h_hi, f.h_lo} * 32'(HUM_SPAN);
			prod = prod / 32'd65535;
			r.humidity_centi = prod[13:0];
		end
		return r;
	endfunction

	// Random frame: mostly well formed, the rest corrupted or noise
	function automatic sensor_frame_t random_frame();
		sensor_frame_t f;
		logic [15:0]   raw_t, raw_h;
		int            pick;
		raw_t = 16'($urandom);
		raw_h = 16'($urandom);
		pick  = $urandom_range(0, 99);
		if (pick < 5) raw_t = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
		if (pick >= 95) raw_h = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
		f = with_crc(raw_t, raw_h);
		pick = $urandom_range(0, 99);
		if (pick >= 90) begin
			f = sensor_frame_t'(48'({$urandom, $urandom}));
		end else if (pick >= 75) begin
			f = sensor_frame_t'(48'(f) ^ (48'd1 << $urandom_range(0, 47)));
		end
		return f;
	endfunction

	// Receiver ready pattern
	always @(posedge clk) begin
		case (stall_mode)
			STALL_NONE:    result.ready <= 1'b1;
			STALL_LIGHT:   result.ready <= ($urandom_range(0, 99) >= 20);
			STALL_PATTERN: result.ready <= stall_pattern[stall_phase];
			default:       result.ready <= ($urandom_range(0, 99) >= 70);
		endcase
		stall_phase <= stall_phase + 4'd1;
	end

	// Predict on every accepted frame beat
	always @(posedge clk) begin
		if (arst_n && frame.valid && frame.ready) begin
			pending_readings.push_back(convert_frame({frame.temperature_high,
				frame.temperature_low, frame.temperature_check, frame.humidity_high,
				frame.humidity_low, frame.humidity_check}));
		end
	end

	// Compare every accepted result beat with the oldest expected reading
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && result.valid && result.ready) begin
			if (pending_readings.size() == 0) begin
				$error("result beat with no frame outstanding");
				error_count++;
			end else begin
				want = pending_readings.pop_front();
				if (result.frame_valid !== want.frame_ok) begin
					$error("frame_valid exp %0d got %0d", want.frame_ok, result.frame_valid);
					error_count++;
				end
				if (result.temperature_centi !== want.temperature_centi) begin
					$error("temperature_centi exp %0d got %0d",
						want.temperature_centi, result.temperature_centi);
					error_count++;
				end
				if (result.humidity_centi !== want.humidity_centi) begin
					$error("humidity_centi exp %0d got %0d",
						want.humidity_centi, result.humidity_centi);
					error_count++;
				end
			end
		end
	end

	// Watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((frame.valid && frame.ready) || (result.valid && result.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Send one frame beat, sometimes with a random gap ahead of it at the start of a burst
	task automatic send_frame(input sensor_frame_t f);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 99) < gap_pct) begin
				frame.valid <= 1'b0;
				repeat ($urandom_range(1, max_gap)) @(posedge clk);
			end
		end
		burst_left--;
		frame.valid             <= 1'b1;
		frame.temperature_high  <= f.t_hi;
		frame.temperature_low   <= f.t_lo;
		frame.temperature_check <= f.t_ck;
		frame.humidity_high     <= f.h_hi;
		frame.humidity_low      <= f.h_lo;
		frame.humidity_check    <= f.h_ck;
		@(posedge clk);
		while (!frame.ready) @(posedge clk);
	endtask

	// Wait for a clock edge first so the last accepted beat is already queued
	task automatic wait_drained();
		@(posedge clk);
		while (pending_readings.size() != 0) @(posedge clk);
	endtask

	// Scale end points and conversion boundaries, all with good CRCs
	task automatic test_scale_points();
		gap_pct    = 0;
		stall_mode = STALL_NONE;
		send_frame(with_crc(16'h0000, 16'h0000));
		send_frame(with_crc(16'hFFFF, 16'hFFFF));
		send_frame(with_crc(16'h0000, 16'hFFFF));
		send_frame(with_crc(16'hFFFF, 16'h0000));
		send_frame(with_crc(16'h8000, 16'h7FFF));
		send_frame(with_crc(16'h7FFF, 16'h8000));
		send_frame(with_crc(16'h0001, 16'h0001));
		send_frame(with_crc(16'h0004, 16'h0007));
		send_frame(with_crc(16'hFFFE, 16'hFFFE));
		send_frame(with_crc(16'hBEEF, 16'h6666));
		send_frame(with_crc(16'h00FF, 16'hFF00));
		send_frame(with_crc(16'hAAAA, 16'h5555));
	endtask

	// CRC mismatch on either word, both words, data or check byte
	task automatic test_crc_faults();
		sensor_frame_t f;
		stall_mode = STALL_LIGHT;
		f = with_crc(16'h6666, 16'h9999);
		f.t_ck = ~f.t_ck;
		send_frame(f);
		f = with_crc(16'h6666, 16'h9999);
		f.h_ck = f.h_ck ^ 8'h01;
		send_frame(f);
		f = with_crc(16'hFFFF, 16'hFFFF);
		f.t_ck = ~f.t_ck;
		f.h_ck = ~f.h_ck;
		send_frame(f);
		f = with_crc(16'h1234, 16'h5678);
		f.t_hi = f.t_hi ^ 8'h80;
		send_frame(f);
		f = with_crc(16'h1234, 16'h5678);
		f.h_lo = f.h_lo ^ 8'h01;
		send_frame(f);
		f = with_crc(16'h0000, 16'h0000);
		f.t_ck = 8'h00;
		f.h_ck = 8'hFF;
		send_frame(f);
		send_frame(sensor_frame_t'('0));
		send_frame(sensor_frame_t'({48{1'b1}}));
	endtask

	// Sender holds off until every reading is back, then resumes
	task automatic test_drain_pause();
		gap_pct    = 30;
		max_gap    = 6;
		stall_mode = STALL_HEAVY;
		for (int round = 0; round < 3; round++) begin
			repeat (20) send_frame(random_frame());
			frame.valid <= 1'b0;
			wait_drained();
			@(posedge clk);
		end
	endtask

	task automatic test_random_traffic(input int count, input int gaps, input int gap_max,
		input stall_mode_t stalls);
		gap_pct       = gaps;
		max_gap       = gap_max;
		stall_pattern = 16'($urandom) | 16'h0001;
		stall_mode    = stalls;
		repeat (count) send_frame(random_frame());
	endtask

	initial begin
		arst_n                  <= 1'b0;
		frame.valid             <= 1'b0;
		frame.temperature_high  <= '0;
		frame.temperature_low   <= '0;
		frame.temperature_check <= '0;
		frame.humidity_high     <= '0;
		frame.humidity_low      <= '0;
		frame.humidity_check    <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_scale_points();
		test_crc_faults();
		test_drain_pause();
		test_random_traffic(400, 0, 1, STALL_NONE);
		test_random_traffic(400, 40, 8, STALL_LIGHT);
		test_random_traffic(400, 25, 4, STALL_PATTERN);
		test_random_traffic(400, 60, 12, STALL_HEAVY);

		frame.valid <= 1'b0;
		stall_mode = STALL_LIGHT;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_readings.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
